### hdl/pdt_pkg.sv
`default_nettype none

package pdt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // result field widths
   localparam int PLANE_INDEX_W  = 6;
   localparam int ENTRIES_USED_W = 7;

   // register reset values: 0.99 in Q1.14, 0.25 in Q8.8
   localparam logic signed [15:0] NORMAL_TOL_RESET   = 16'sd16220;
   localparam logic        [15:0] DISTANCE_TOL_RESET = 16'd64;

   // register indexes
   localparam logic CSR_NORMAL_TOL   = 1'b0;
   localparam logic CSR_DISTANCE_TOL = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_FIND  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   // one stored plane, x normal in the lowest bits
   typedef struct packed {
      logic signed [31:0] plane_offset;
      logic signed [15:0] normal_z;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_x;
   } plane_type;

   // tag that rides along with a table read through the compare pipe
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
   } scan_tag_type;

   // compare outcome for one table entry
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
      logic              hit;
   } match_result_type;

   // result beat, plane index in the lowest bits
   typedef struct packed {
      logic                      pad;
      logic [ENTRIES_USED_W-1:0] entries_used;
      logic                      table_full;
      logic                      matched;
      logic [PLANE_INDEX_W-1:0]  plane_index;
   } rsp_fields_type;

endpackage

`default_nettype wire

### hdl/pdt_store.sv
`default_nettype none

module pdt_store (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [pdt_pkg::ADDR_W-1:0] wr_addr,
   input  wire pdt_pkg::plane_type         wr_data,
   input  wire logic                       rd_en,
   input  wire logic [pdt_pkg::ADDR_W-1:0] rd_addr,
   output pdt_pkg::plane_type              rd_data
);

   pdt_pkg::plane_type mem [pdt_pkg::TABLE_DEPTH];
   pdt_pkg::plane_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/pdt_match.sv
`default_nettype none

module pdt_match (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pdt_pkg::scan_tag_type     in_tag,
   input  wire pdt_pkg::plane_type        entry,
   input  wire pdt_pkg::plane_type        query,
   input  wire logic signed [15:0]        normal_tol,
   input  wire logic        [15:0]        distance_tol,
   output pdt_pkg::match_result_type      result
);

   // stage 1: products and raw distance difference
   pdt_pkg::scan_tag_type    tag1_ff;
   logic signed [31:0]       prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [31:0]       prod_x_in, prod_y_in, prod_z_in;
   logic signed [32:0]       diff_ff, diff_in;

   // stage 2: dot product and absolute difference
   pdt_pkg::scan_tag_type    tag2_ff;
   logic signed [33:0]       dot_ff, dot_in;
   logic        [32:0]       abs_diff_ff, abs_diff_in;

   // stage 3: verdict
   pdt_pkg::match_result_type result_ff, result_in;
   logic signed [33:0]        normal_limit;

   always_comb begin
      prod_x_in = entry.normal_x * query.normal_x;
      prod_y_in = entry.normal_y * query.normal_y;
      prod_z_in = entry.normal_z * query.normal_z;
      diff_in   = $signed({entry.plane_offset[31], entry.plane_offset})
                - $signed({query.plane_offset[31], query.plane_offset});
   end

   always_comb begin
      dot_in      = 34'(prod_x_ff) + 34'(prod_y_ff) + 34'(prod_z_ff);
      abs_diff_in = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
   end

   // tolerance scaled to Q5.28
   assign normal_limit = $signed({{4{normal_tol[15]}}, normal_tol, 14'b0});

   always_comb begin
      result_in.valid = tag2_ff.valid;
      result_in.index = tag2_ff.index;
      result_in.hit   = (dot_ff > normal_limit) && (abs_diff_ff < {17'b0, distance_tol});
   end

   // advance the tags and the verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         result_ff <= '0;
      end else begin
         tag1_ff   <= in_tag;
         tag2_ff   <= tag1_ff;
         result_ff <= result_in;
      end
   end

   // advance the data
   always_ff @(posedge clock) begin
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      prod_z_ff   <= prod_z_in;
      diff_ff     <= diff_in;
      dot_ff      <= dot_in;
      abs_diff_ff <= abs_diff_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### hdl/plane_dedup_table.sv
// Plane table with tolerance-based deduplication.
// Request beats on req_* carry an op in req_tuser and a plane in req_tdata.
// An add returns the first matching stored plane, appends the plane or flags table_full;
// a find returns the first match or matched low; a clear empties the table.
// Each request gives exactly one response beat on rsp_*.
// Registers are written on csr_* (index 0 normal tolerance, index 1 distance
// tolerance); csr_ready is always high and writes belong in idle periods.
// A scan walks the stored planes with one table read per cycle feeding a
// three-stage compare pipe; a hit stops further reads and the scan ends
// once the reads in flight are compared. A clear, an unused op or an add or
// find on an empty table skips the table walk. One request is in work at a
// time; the next is accepted once the previous response sits in the output
// register, even if it is not taken.
// Reset empties the table and restores the tolerances to 0.99 and 0.25.
// While rsp_tready is low the response holds and a finished request waits
// before its response is loaded, so back-pressure stalls the next request.
`default_nettype none

module plane_dedup_table (
   input  wire logic        clock,
   input  wire logic        reset,
   // normal_x, normal_y, normal_z, plane_offset
   input  wire logic [79:0] req_tdata,
   // op
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // plane_index, matched, table_full, entries_used, zero pad
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        csr_valid,
   output logic             csr_ready
);

   localparam int AW = pdt_pkg::ADDR_W;
   localparam int CW = pdt_pkg::COUNT_W;

   pdt_pkg::state_type        state_ff, state_in;
   pdt_pkg::op_type           op_ff, op_in;
   pdt_pkg::plane_type        query_ff, query_in;
   logic [CW-1:0]             limit_ff, limit_in;
   logic [CW-1:0]             issue_cnt_ff, issue_cnt_in;
   logic [CW-1:0]             recv_cnt_ff, recv_cnt_in;
   logic [CW-1:0]             used_ff, used_in;
   logic                      found_ff, found_in;
   logic [AW-1:0]             found_idx_ff, found_idx_in;
   pdt_pkg::rsp_fields_type   res_ff, res_in;
   pdt_pkg::rsp_fields_type   rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]        normal_tol_ff;
   logic        [15:0]        distance_tol_ff;

   logic                      rd_en;
   pdt_pkg::scan_tag_type     rd_tag_ff;
   pdt_pkg::plane_type        rd_data;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   pdt_pkg::match_result_type match_out;
   logic                      scan_done;

   pdt_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (query_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   pdt_match u_match (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (rd_tag_ff),
      .entry        (rd_data),
      .query        (query_ff),
      .normal_tol   (normal_tol_ff),
      .distance_tol (distance_tol_ff),
      .result       (match_out)
   );

   // scan ends when a hit is seen or all entries compared, and the pipe is empty
   assign scan_done = (found_ff || (recv_cnt_ff == limit_ff)) && (recv_cnt_ff == issue_cnt_ff);

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      query_in     = query_ff;
      limit_in     = limit_ff;
      issue_cnt_in = issue_cnt_ff;
      recv_cnt_in  = recv_cnt_ff;
      used_in      = used_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = used_ff[AW-1:0];

      // drop the response once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pdt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in        = pdt_pkg::op_type'(req_tuser);
               query_in     = pdt_pkg::plane_type'(req_tdata);
               issue_cnt_in = '0;
               recv_cnt_in  = '0;
               found_in     = 1'b0;
               if (op_in == pdt_pkg::OP_ADD || op_in == pdt_pkg::OP_FIND) begin
                  limit_in = used_ff;
               end else begin
                  limit_in = '0;
               end
               state_in = pdt_pkg::ST_SCAN;
            end
         end

         pdt_pkg::ST_SCAN: begin
            // issue one table read per cycle until all entries are read or a hit shows up
            rd_en = (issue_cnt_ff < limit_ff) && !found_ff;
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + CW'(1);
            end
            // collect compare results; the first hit is the lowest index
            if (match_out.valid) begin
               recv_cnt_in = recv_cnt_ff + CW'(1);
               if (match_out.hit && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = match_out.index;
               end
            end
            if (scan_done) begin
               res_in = '0;
               case (op_ff)
                  pdt_pkg::OP_ADD: begin
                     if (found_ff) begin
                        res_in.plane_index = pdt_pkg::PLANE_INDEX_W'(found_idx_ff);
                        res_in.matched     = 1'b1;
                     end else if (used_ff < CW'(pdt_pkg::TABLE_DEPTH)) begin
                        wr_en              = 1'b1;
                        res_in.plane_index = pdt_pkg::PLANE_INDEX_W'(used_ff[AW-1:0]);
                        used_in            = used_ff + CW'(1);
                     end else begin
                        res_in.table_full = 1'b1;
                     end
                  end
                  pdt_pkg::OP_FIND: begin
                     if (found_ff) begin
                        res_in.plane_index = pdt_pkg::PLANE_INDEX_W'(found_idx_ff);
                        res_in.matched     = 1'b1;
                     end
                  end
                  pdt_pkg::OP_CLEAR: begin
                     used_in = '0;
                  end
                  default: begin
                  end
               endcase
               res_in.entries_used = pdt_pkg::ENTRIES_USED_W'(used_in);
               state_in            = pdt_pkg::ST_OUT;
            end
         end

         pdt_pkg::ST_OUT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = pdt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pdt_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdt_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         issue_cnt_ff <= '0;
         recv_cnt_ff  <= '0;
         limit_ff     <= '0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         issue_cnt_ff <= issue_cnt_in;
         recv_cnt_ff  <= recv_cnt_in;
         limit_ff     <= limit_in;
         rd_tag_ff    <= '{valid: rd_en, index: issue_cnt_ff[AW-1:0]};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      query_ff     <= query_in;
      found_idx_ff <= found_idx_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_tol_ff   <= pdt_pkg::NORMAL_TOL_RESET;
         distance_tol_ff <= pdt_pkg::DISTANCE_TOL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pdt_pkg::CSR_NORMAL_TOL:   normal_tol_ff   <= $signed(csr_data);
            pdt_pkg::CSR_DISTANCE_TOL: distance_tol_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### dv/plane_dedup_table_test.sv
`timescale 1ns / 1ps

module plane_dedup_table_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 11;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int FIRST_ITEMS  = 180;
   localparam int LATER_ITEMS  = 100;
   localparam int MAX_REPORTS  = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic [79:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_data   = '0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;

   // mirror of the table and the tolerance registers
   pdt_pkg::plane_type stored_planes [pdt_pkg::TABLE_DEPTH];
   int                 planes_held  = 0;
   logic signed [15:0] normal_limit = pdt_pkg::NORMAL_TOL_RESET;
   logic [15:0]        offset_limit = pdt_pkg::DISTANCE_TOL_RESET;

   pdt_pkg::rsp_fields_type pending_results [$];
   int mismatches    = 0;
   int send_idle_pct = 6;
   int recv_idle_pct = 68;
   bit hold_toggle   = 1'b0;
   bit hold_seen     = 1'b0;
   int hold_left     = 0;

   // one row of the directed walk; typed rows carry their own expected beat
   typedef struct {
      logic [1:0]         op;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [31:0] offset;
      bit                 typed;
      logic [5:0]         index;
      bit                 hit;
      bit                 full;
      logic [6:0]         used;
   } step_row_type;

   step_row_type directed_rows [22] = '{
      '{pdt_pkg::OP_FIND,   16384,      0,      0, 32'h0000_0000, 1, 0, 0, 0, 0},
      '{OP_UNUSED,          16384,      0,      0, 32'h0000_0000, 1, 0, 0, 0, 0},
      '{pdt_pkg::OP_CLEAR,  16'h8000, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,    16384,      0,      0, 32'h0000_0000, 1, 0, 0, 0, 1},
      '{pdt_pkg::OP_ADD,    16384,      0,      0, 32'h0000_0000, 1, 0, 1, 0, 1},
      '{pdt_pkg::OP_FIND,   16384,      0,      0, 32'h0000_003F, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,   16384,      0,      0, 32'h0000_0040, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,   16384,      0,      0, 32'hFFFF_FFC1, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,   16220,      0,      0, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,   16221,      0,      0, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,   -16384,      0,      0, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,        0,  16384,      0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,        0,      0, -16384, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,       0,      0, -16384, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,        0, -16384,      0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,  16'h7FFF, 16'h8000, 16'h7FFF, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,   -16384, -16384, -16384, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{OP_UNUSED,              0,      0,      0, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,       0,  16384,      0, 32'h7FFF_FFC1, 0, 0, 0, 0, 0},
      '{pdt_pkg::OP_CLEAR,      0,      0,      0, 32'h0000_0000, 1, 0, 0, 0, 0},
      '{pdt_pkg::OP_FIND,   16384,      0,      0, 32'h0000_0000, 1, 0, 0, 0, 0},
      '{pdt_pkg::OP_ADD,        0,      0,  16384, 32'hFFFF_FF00, 1, 0, 0, 0, 1}
   };

   always #HALF_PERIOD clock = ~clock;

   plane_dedup_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // two planes coincide when the normals point the same way and the offsets are close
   function automatic bit planes_coincide(pdt_pkg::plane_type a, pdt_pkg::plane_type b);
      longint dot;
      longint gap;
      dot = longint'(a.normal_x) * longint'(b.normal_x)
          + longint'(a.normal_y) * longint'(b.normal_y)
          + longint'(a.normal_z) * longint'(b.normal_z);
      gap = longint'(a.plane_offset) - longint'(b.plane_offset);
      if (gap < 0) gap = -gap;
      return dot > longint'(normal_limit) * 16384 && gap < longint'(offset_limit);
   endfunction

   // apply one operation to the mirror table and return the response beat
   function automatic pdt_pkg::rsp_fields_type apply_plane_op(logic [1:0] op,
                                                              pdt_pkg::plane_type p);
      pdt_pkg::rsp_fields_type r;
      int hit_at;
      r = '0;
      hit_at = -1;
      if (op == pdt_pkg::OP_ADD || op == pdt_pkg::OP_FIND) begin
         for (int i = 0; i < planes_held; i++) begin
            if (planes_coincide(stored_planes[i], p)) begin
               hit_at = i;
               break;
            end
         end
      end
      case (op)
         pdt_pkg::OP_ADD: begin
            if (hit_at >= 0) begin
               r.plane_index = 6'(hit_at);
               r.matched     = 1'b1;
            end else if (planes_held < pdt_pkg::TABLE_DEPTH) begin
               r.plane_index = 6'(planes_held);
               stored_planes[planes_held] = p;
               planes_held++;
            end else begin
               r.table_full = 1'b1;
            end
         end
         pdt_pkg::OP_FIND: begin
            if (hit_at >= 0) begin
               r.plane_index = 6'(hit_at);
               r.matched     = 1'b1;
            end
         end
         pdt_pkg::OP_CLEAR: begin
            planes_held = 0;
         end
         default: ;
      endcase
      r.entries_used = 7'(planes_held);
      return r;
   endfunction

   // random plane: axis-aligned or arbitrary unit-range normal, any offset
   function automatic pdt_pkg::plane_type fresh_plane();
      pdt_pkg::plane_type p;
      logic signed [15:0] axis_value;
      p = '0;
      if ($urandom_range(1)) begin
         p.normal_x = 16'($urandom_range(32768) - 16384);
         p.normal_y = 16'($urandom_range(32768) - 16384);
         p.normal_z = 16'($urandom_range(32768) - 16384);
      end else begin
         axis_value = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         case ($urandom_range(2))
            0:       p.normal_x = axis_value;
            1:       p.normal_y = axis_value;
            default: p.normal_z = axis_value;
         endcase
      end
      p.plane_offset = $urandom;
      return p;
   endfunction

   // stored plane nudged around the tolerance edges; needs a non-empty table
   function automatic pdt_pkg::plane_type near_copy();
      pdt_pkg::plane_type p;
      int step;
      p = stored_planes[$urandom_range(planes_held - 1)];
      case ($urandom_range(5))
         0:       step = 0;
         1:       step = int'(offset_limit) - 1;
         2:       step = int'(offset_limit);
         3:       step = 1 - int'(offset_limit);
         4:       step = -int'(offset_limit);
         default: step = int'($urandom_range(2 * offset_limit)) - int'(offset_limit);
      endcase
      p.plane_offset += step;
      if ($urandom_range(1)) begin
         p.normal_x = 16'(p.normal_x + $urandom_range(16) - 8);
         p.normal_y = 16'(p.normal_y + $urandom_range(16) - 8);
         p.normal_z = 16'(p.normal_z + $urandom_range(16) - 8);
      end
      return p;
   endfunction

   // offer one request beat, idling first at the sender rate
   task automatic send_plane_op(logic [1:0] op, pdt_pkg::plane_type p, bit typed = 1'b0,
                                pdt_pkg::rsp_fields_type typed_beat = '0);
      pdt_pkg::rsp_fields_type predicted;
      pdt_pkg::rsp_fields_type expected;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= p;
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_plane_op(op, p);
      expected  = typed ? typed_beat : predicted;
      pending_results = {pending_results, expected};
   endtask

   // mostly adds and lookups, some near stored planes, with clears and noise mixed in
   task automatic send_random_op();
      pdt_pkg::plane_type p;
      logic [1:0] op;
      int unsigned roll;
      roll = $urandom_range(99);
      p  = fresh_plane();
      op = pdt_pkg::OP_ADD;
      if (roll < 40) begin
         op = pdt_pkg::OP_ADD;
      end else if (roll < 65) begin
         op = $urandom_range(1) ? pdt_pkg::OP_ADD : pdt_pkg::OP_FIND;
         if (planes_held != 0) p = near_copy();
      end else if (roll < 78) begin
         op = pdt_pkg::OP_FIND;
      end else if (roll < 81) begin
         op = pdt_pkg::OP_CLEAR;
      end else if (roll < 85) begin
         op = OP_UNUSED;
      end else begin
         op = 2'($urandom_range(3));
         p  = {$urandom, $urandom, 16'($urandom)};
      end
      send_plane_op(op, p);
   endtask

   // fill the table, then push adds against the full table
   task automatic fill_table();
      int guard;
      guard = 0;
      while (planes_held < pdt_pkg::TABLE_DEPTH && guard < 2 * pdt_pkg::TABLE_DEPTH) begin
         send_plane_op(pdt_pkg::OP_ADD, fresh_plane());
         guard++;
      end
      repeat (8) begin
         if ($urandom_range(1) && planes_held != 0) send_plane_op(pdt_pkg::OP_ADD, near_copy());
         else send_plane_op(pdt_pkg::OP_ADD, fresh_plane());
      end
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // write both tolerance registers with the block idle
   task automatic set_tolerances(logic signed [15:0] ntol, logic [15:0] dtol);
      wait_until_drained();
      csr_index <= pdt_pkg::CSR_NORMAL_TOL;
      csr_data  <= ntol;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      normal_limit = ntol;
      csr_index <= pdt_pkg::CSR_DISTANCE_TOL;
      csr_data  <= dtol;
      do @(posedge clock); while (!csr_ready);
      offset_limit = dtol;
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen  <= 1'b0;
         hold_left  <= 0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each response beat with the oldest expected one
   always @(posedge clock) begin
      pdt_pkg::rsp_fields_type got;
      pdt_pkg::rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response index %0d matched %0b full %0b used %0d",
                        $time, got.plane_index, got.matched, got.table_full,
                        got.entries_used);
         end else begin
            want = pending_results.pop_front();
            if (got.plane_index !== want.plane_index || got.matched !== want.matched ||
                got.table_full !== want.table_full ||
                got.entries_used !== want.entries_used) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: response mismatch, expected index %0d matched %0b",
                            " full %0b used %0d, got index %0d matched %0b full %0b",
                            " used %0d"},
                           $time, want.plane_index, want.matched, want.table_full,
                           want.entries_used, got.plane_index, got.matched,
                           got.table_full, got.entries_used);
            end
         end
      end
   end

   initial begin
      pdt_pkg::plane_type      p;
      pdt_pkg::rsp_fields_type beat;
      step_row_type            row;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed walk with reset tolerances
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         p.normal_x     = row.nx;
         p.normal_y     = row.ny;
         p.normal_z     = row.nz;
         p.plane_offset = row.offset;
         beat = '0;
         beat.plane_index  = row.index;
         beat.matched      = row.hit;
         beat.table_full   = row.full;
         beat.entries_used = row.used;
         send_plane_op(row.op, p, row.typed, beat);
      end

      // loosest tolerances, slow receiver
      set_tolerances(-16'sd16384, 16'd65535);
      repeat (FIRST_ITEMS) send_random_op();

      // strictest tolerances, slow sender
      set_tolerances(16'sd16384, 16'd0);
      send_idle_pct = 68;
      recv_idle_pct = 6;
      fill_table();
      repeat (LATER_ITEMS) send_random_op();

      // mid tolerances, no idling, long receiver hold-off while the table fills
      set_tolerances(16'sd15000, 16'd4096);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      fill_table();
      repeat (LATER_ITEMS) send_random_op();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
